// ----- hw/rtl/rgblf_pkg.sv -----
// ----------------------------------------------------------------------------
// RGB LED fade/blink controller package
// Shared types, codes and constants of the LED fade/blink controller.
// ----------------------------------------------------------------------------
`default_nettype none

package rgblf_pkg;

  localparam int LEVEL_W     = 8;
  localparam int DUR_W       = 16;
  localparam int FADE_RATE_W = 10;
  localparam int PRESCALE_W  = 10;
  localparam int FADE_CNT_W  = 18;
  localparam int MS_CNT_W    = 17;
  localparam int CFG_IDX_W   = 1;
  localparam int CFG_DATA_W  = FADE_RATE_W;
  localparam int NUM_LANES   = 3;

  localparam int DEF_US_PER_MS        = 1000;
  localparam int DEF_FADE_UNIT_US     = 250;
  localparam int DEF_OFFLINE_BLINK_MS = 1000;

  localparam logic [LEVEL_W-1:0] LEVEL_FULL = 8'd255;
  localparam logic [LEVEL_W-1:0] LEVEL_DARK = 8'd0;
  localparam logic [LEVEL_W-1:0] GREEN_BOOT = 8'd30;

  typedef enum logic [1:0] {
    MODE_TICK  = 2'd0,
    MODE_SET   = 2'd1,
    MODE_FLASH = 2'd2,
    MODE_BLINK = 2'd3
  } mode_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_LED_ENABLE = 1'd0,
    CFG_FADE_RATE  = 1'd1
  } cfg_idx_t;

  typedef enum logic [1:0] {
    PRE_KEEP,
    PRE_DARK,
    PRE_OFFLINE
  } pre_sel_t;

  typedef enum logic [1:0] {
    POST_KEEP,
    POST_DARK,
    POST_BLINK
  } post_sel_t;

  typedef struct packed {
    logic      fire;
    logic      load_target;
    logic      load_blink;
    pre_sel_t  pre;
    logic      step;
    logic      jump;
    post_sel_t post;
  } lane_ctl_t;

  typedef struct packed {
    logic [LEVEL_W-1:0] red;
    logic [LEVEL_W-1:0] green;
    logic [LEVEL_W-1:0] blue;
    logic               offline;
  } result_t;

endpackage

`default_nettype wire

// ----- hw/rtl/rgblf_if.sv -----
// ----------------------------------------------------------------------------
// RGB LED fade/blink controller channels
// Command input channel and level output channel, valid/ready handshake.
// ----------------------------------------------------------------------------
`default_nettype none

interface rgblf_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  mode;
  logic [7:0]  red_in;
  logic [7:0]  green_in;
  logic [7:0]  blue_in;
  logic [15:0] duration_ms;
  logic        link_up;

  modport source (
    output valid, mode, red_in, green_in, blue_in, duration_ms, link_up,
    input  ready
  );
  modport sink (
    input  valid, mode, red_in, green_in, blue_in, duration_ms, link_up,
    output ready
  );
endinterface

interface rgblf_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] red_level;
  logic [7:0] green_level;
  logic [7:0] blue_level;
  logic       offline_flag;

  modport source (
    output valid, red_level, green_level, blue_level, offline_flag,
    input  ready
  );
  modport sink (
    input  valid, red_level, green_level, blue_level, offline_flag,
    output ready
  );
endinterface

`default_nettype wire

// ----- hw/rtl/rgblf_lane.sv -----
// ----------------------------------------------------------------------------
// RGB LED fade/blink color lane
// Holds shown, target and blink level of one color and steps it per word.
// ----------------------------------------------------------------------------
`default_nettype none

module rgblf_lane
  import rgblf_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire lane_ctl_t          ctl,
  input  wire logic [LEVEL_W-1:0] cmd_level,
  input  wire logic [LEVEL_W-1:0] reset_level,
  input  wire logic [LEVEL_W-1:0] offline_level,
  output logic                    differ,
  output logic [LEVEL_W-1:0]      shown_cur,
  output logic [LEVEL_W-1:0]      shown_upd
);

  logic [LEVEL_W-1:0] shown;
  logic [LEVEL_W-1:0] target;
  logic [LEVEL_W-1:0] blink;
  logic [LEVEL_W-1:0] target_next;
  logic [LEVEL_W-1:0] blink_next;
  logic [LEVEL_W-1:0] target_pre;

  always_comb begin
    case (ctl.pre)
      PRE_DARK:    target_pre = LEVEL_DARK;
      PRE_OFFLINE: target_pre = offline_level;
      default:     target_pre = target;
    endcase
  end

  assign differ = (target_pre != shown);

  always_comb begin
    blink_next = (ctl.pre == PRE_OFFLINE) ? offline_level : blink;
    if (ctl.load_blink) begin
      blink_next = cmd_level;
    end
  end

  always_comb begin
    shown_upd = shown;
    if (ctl.jump) begin
      shown_upd = target_pre;
    end else if (ctl.step) begin
      if (target_pre > shown) begin
        shown_upd = shown + LEVEL_W'(1);
      end else if (target_pre < shown) begin
        shown_upd = shown - LEVEL_W'(1);
      end
    end
  end

  always_comb begin
    case (ctl.post)
      POST_DARK:  target_next = LEVEL_DARK;
      POST_BLINK: target_next = blink_next;
      default:    target_next = target_pre;
    endcase
    if (ctl.load_target) begin
      target_next = cmd_level;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      shown  <= reset_level;
      target <= LEVEL_DARK;
      blink  <= LEVEL_DARK;
    end else if (ctl.fire) begin
      shown  <= shown_upd;
      target <= target_next;
      blink  <= blink_next;
    end
  end

  assign shown_cur = shown;

endmodule

`default_nettype wire

// ----- hw/rtl/rgblf_ctrl.sv -----
// ----------------------------------------------------------------------------
// RGB LED fade/blink timing control
// Time base, flash and blink timers, link handling and configuration.
// ----------------------------------------------------------------------------
`default_nettype none

module rgblf_ctrl
  import rgblf_pkg::*;
#(
  parameter int US_PER_MS        = DEF_US_PER_MS,
  parameter int FADE_UNIT_US     = DEF_FADE_UNIT_US,
  parameter int OFFLINE_BLINK_MS = DEF_OFFLINE_BLINK_MS
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  wr_en,
  input  wire logic [CFG_IDX_W-1:0]  wr_index,
  input  wire logic [CFG_DATA_W-1:0] wr_data,
  input  wire logic                  fire,
  input  wire logic [1:0]            mode,
  input  wire logic [DUR_W-1:0]      duration_ms,
  input  wire logic                  link_up,
  input  wire logic                  differ,
  output lane_ctl_t                  ctl,
  output logic                       offline_upd
);

  localparam int THR_W = $clog2(((1 << FADE_RATE_W) - 1) * FADE_UNIT_US + 1);
  localparam int CMP_W = (THR_W > FADE_CNT_W) ? THR_W : FADE_CNT_W;

  logic                  led_enable;
  logic [THR_W-1:0]      fade_thresh;
  logic [FADE_CNT_W-1:0] fade_us;
  logic [PRESCALE_W-1:0] prescale;
  logic [MS_CNT_W-1:0]   flash_ms;
  logic [MS_CNT_W-1:0]   blink_ms;
  logic [DUR_W-1:0]      flash_len;
  logic [DUR_W-1:0]      blink_half;
  logic                  offline;

  logic [FADE_CNT_W-1:0] fade_us_next;
  logic [PRESCALE_W-1:0] prescale_next;
  logic [MS_CNT_W-1:0]   flash_ms_next;
  logic [MS_CNT_W-1:0]   blink_ms_next;
  logic [DUR_W-1:0]      flash_len_next;
  logic [DUR_W-1:0]      blink_half_next;
  logic                  offline_next;

  logic                  is_tick;
  logic                  lost;
  logic [FADE_CNT_W-1:0] fade_us_inc;
  logic [PRESCALE_W-1:0] prescale_inc;
  logic                  ms_wrap;
  logic [MS_CNT_W-1:0]   flash_ms_inc;
  logic [MS_CNT_W-1:0]   blink_ms_inc;
  pre_sel_t              pre_sel;
  logic                  step;
  logic                  jump;
  post_sel_t             post_sel;

  assign is_tick = fire && (mode_t'(mode) == MODE_TICK);
  assign lost    = !link_up && !offline;

  assign fade_us_inc  = (&fade_us) ? fade_us : fade_us + FADE_CNT_W'(1);
  assign prescale_inc = prescale + PRESCALE_W'(1);
  assign ms_wrap      = (prescale_inc >= PRESCALE_W'(US_PER_MS));
  assign flash_ms_inc = (ms_wrap && !(&flash_ms)) ? flash_ms + MS_CNT_W'(1) : flash_ms;
  assign blink_ms_inc = (ms_wrap && !(&blink_ms)) ? blink_ms + MS_CNT_W'(1) : blink_ms;

  always_comb begin
    pre_sel = PRE_KEEP;
    if (is_tick) begin
      if (lost) begin
        pre_sel = PRE_OFFLINE;
      end else if (!led_enable) begin
        pre_sel = PRE_DARK;
      end
    end
  end

  always_comb begin
    fade_us_next    = fade_us;
    prescale_next   = prescale;
    flash_ms_next   = flash_ms;
    blink_ms_next   = blink_ms;
    flash_len_next  = flash_len;
    blink_half_next = blink_half;
    offline_next    = offline;
    step            = 1'b0;
    jump            = 1'b0;
    post_sel        = POST_KEEP;
    if (fire) begin
      case (mode_t'(mode))
        MODE_TICK: begin
          fade_us_next  = fade_us_inc;
          prescale_next = ms_wrap ? '0 : prescale_inc;
          flash_ms_next = flash_ms_inc;
          blink_ms_next = blink_ms_inc;
          if (lost) begin
            blink_ms_next   = '0;
            blink_half_next = DUR_W'(OFFLINE_BLINK_MS);
            flash_len_next  = '0;
            offline_next    = 1'b1;
          end else if (!led_enable) begin
            blink_half_next = '0;
            flash_len_next  = '0;
          end
          if (link_up) begin
            offline_next = 1'b0;
          end
          if (differ) begin
            if (fade_thresh != '0) begin
              if (CMP_W'(fade_us_inc) >= CMP_W'(fade_thresh)) begin
                fade_us_next = '0;
                step         = 1'b1;
              end
            end else begin
              jump = 1'b1;
            end
          end
          if ((flash_len_next != '0) && (flash_ms_inc >= {1'b0, flash_len_next})) begin
            flash_len_next = '0;
            post_sel       = POST_DARK;
          end
          if (blink_half_next != '0) begin
            if (blink_ms_next >= {1'b0, blink_half_next}) begin
              post_sel = POST_BLINK;
            end
            if (blink_ms_next >= {blink_half_next, 1'b0}) begin
              post_sel      = POST_DARK;
              blink_ms_next = '0;
            end
          end
        end
        MODE_SET: begin
          blink_half_next = '0;
          flash_len_next  = '0;
        end
        MODE_FLASH: begin
          flash_ms_next   = '0;
          flash_len_next  = duration_ms;
          blink_half_next = '0;
        end
        MODE_BLINK: begin
          blink_ms_next   = '0;
          blink_half_next = duration_ms;
          flash_len_next  = '0;
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    ctl.fire        = fire;
    ctl.load_target = fire && (mode_t'(mode) != MODE_TICK);
    ctl.load_blink  = fire && (mode_t'(mode) == MODE_BLINK);
    ctl.pre         = pre_sel;
    ctl.step        = step;
    ctl.jump        = jump;
    ctl.post        = post_sel;
  end

  assign offline_upd = offline_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      led_enable  <= 1'b1;
      fade_thresh <= '0;
    end else if (wr_en) begin
      case (cfg_idx_t'(wr_index))
        CFG_LED_ENABLE: led_enable  <= wr_data[0];
        CFG_FADE_RATE:  fade_thresh <= THR_W'(32'(wr_data) * FADE_UNIT_US);
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fade_us    <= '0;
      prescale   <= '0;
      flash_ms   <= '0;
      blink_ms   <= '0;
      flash_len  <= '0;
      blink_half <= '0;
      offline    <= 1'b0;
    end else begin
      fade_us    <= fade_us_next;
      prescale   <= prescale_next;
      flash_ms   <= flash_ms_next;
      blink_ms   <= blink_ms_next;
      flash_len  <= flash_len_next;
      blink_half <= blink_half_next;
      offline    <= offline_next;
    end
  end

endmodule

`default_nettype wire

// ----- hw/rtl/rgb_led_fade_blink_controller_unit.sv -----
// Results are registered in the output register, or in the skid while that is occupied.
// Throughput: one word per cycle unless the skid is full; state settles on acceptance.
// A two-entry output stage (register plus skid) keeps input ready while a result waits.
// Reset is synchronous: levels return to red 0, green 30, blue 255, LED enabled,
// fade rate zero, timers and the offline latch cleared.
// ----------------------------------------------------------------------------
// RGB LED fade/blink controller top level
// Three color lanes under one timing control, merged into one result word.
// ----------------------------------------------------------------------------
`default_nettype none

module rgb_led_fade_blink_controller_unit
  import rgblf_pkg::*;
#(
  parameter int US_PER_MS        = DEF_US_PER_MS,
  parameter int FADE_UNIT_US     = DEF_FADE_UNIT_US,
  parameter int OFFLINE_BLINK_MS = DEF_OFFLINE_BLINK_MS
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  wr_en,
  input  wire logic [CFG_IDX_W-1:0]  wr_index,
  input  wire logic [CFG_DATA_W-1:0] wr_data,
  rgblf_in_if.sink                   in_ch,
  rgblf_out_if.source                out_ch
);

  lane_ctl_t          ctl;
  logic               fire;
  logic               take;
  logic               differ;
  logic [2:0]         lane_differ;
  logic               offline_upd;
  result_t            result;
  result_t            result_cur;
  result_t            main_word;
  result_t            skid_word;
  logic               main_valid;
  logic               skid_valid;

  assign in_ch.ready = !skid_valid;
  assign fire        = in_ch.valid && in_ch.ready;
  assign take        = main_valid && out_ch.ready;

  rgblf_ctrl #(
    .US_PER_MS        (US_PER_MS),
    .FADE_UNIT_US     (FADE_UNIT_US),
    .OFFLINE_BLINK_MS (OFFLINE_BLINK_MS)
  ) u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .wr_en       (wr_en),
    .wr_index    (wr_index),
    .wr_data     (wr_data),
    .fire        (fire),
    .mode        (in_ch.mode),
    .duration_ms (in_ch.duration_ms),
    .link_up     (in_ch.link_up),
    .differ      (differ),
    .ctl         (ctl),
    .offline_upd (offline_upd)
  );

  rgblf_lane u_red (
    .clk           (clk),
    .rst           (rst),
    .ctl           (ctl),
    .cmd_level     (in_ch.red_in),
    .reset_level   (LEVEL_DARK),
    .offline_level (LEVEL_FULL),
    .differ        (lane_differ[0]),
    .shown_cur     (result_cur.red),
    .shown_upd     (result.red)
  );

  rgblf_lane u_green (
    .clk           (clk),
    .rst           (rst),
    .ctl           (ctl),
    .cmd_level     (in_ch.green_in),
    .reset_level   (GREEN_BOOT),
    .offline_level (LEVEL_DARK),
    .differ        (lane_differ[1]),
    .shown_cur     (result_cur.green),
    .shown_upd     (result.green)
  );

  rgblf_lane u_blue (
    .clk           (clk),
    .rst           (rst),
    .ctl           (ctl),
    .cmd_level     (in_ch.blue_in),
    .reset_level   (LEVEL_FULL),
    .offline_level (LEVEL_DARK),
    .differ        (lane_differ[2]),
    .shown_cur     (result_cur.blue),
    .shown_upd     (result.blue)
  );

  assign differ             = |lane_differ;
  assign result.offline     = offline_upd;
  assign result_cur.offline = 1'b0;

  always_ff @(posedge clk) begin
    if (rst) begin
      main_valid <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!main_valid || take) begin
      if (skid_valid) begin
        main_valid <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        main_valid <= fire;
      end
    end else if (fire) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!main_valid || take) begin
      if (skid_valid) begin
        main_word <= skid_word;
      end else if (fire) begin
        main_word <= result;
      end
    end else if (fire) begin
      skid_word <= result;
    end
  end

  assign out_ch.valid        = main_valid;
  assign out_ch.red_level    = main_word.red;
  assign out_ch.green_level  = main_word.green;
  assign out_ch.blue_level   = main_word.blue;
  assign out_ch.offline_flag = main_word.offline;

  a_skid_behind_main: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> main_valid)
    else $error("Skid word held while the output register is empty.");

  a_cmd_keeps_levels: assert property (@(posedge clk) disable iff (rst)
    (fire && (mode_t'(in_ch.mode) != MODE_TICK)) |->
      (result.red == result_cur.red && result.green == result_cur.green &&
       result.blue == result_cur.blue))
    else $error("A command word moved the shown levels.");

  a_link_clears_offline: assert property (@(posedge clk) disable iff (rst)
    (fire && (mode_t'(in_ch.mode) == MODE_TICK) && in_ch.link_up) |-> !result.offline)
    else $error("Offline flag set on a tick with the link up.");

  a_fade_one_step: assert property (@(posedge clk) disable iff (rst)
    (fire && ctl.step) |->
      (result.red - result_cur.red == 8'd1 || result_cur.red - result.red == 8'd1 ||
       result.red == result_cur.red))
    else $error("Fade step moved red by more than one.");

endmodule

`default_nettype wire

// ----- dv/tb_rgb_led_fade_blink_controller_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// RGB LED fade/blink controller testbench
// Sends color commands and microsecond ticks through the input channel with
// random idling on both sides. Each level word is predicted from a local
// copy of the controller state and checked field by field on the output.
// ----------------------------------------------------------------------------
module tb_rgb_led_fade_blink_controller_unit;
  import rgblf_pkg::*;

  localparam int LONG_HOLD    = 200;
  localparam int RANDOM_WORDS = 480;
  localparam int RANDOM_SETS  = 6;

  typedef struct {
    mode_t              mode;
    logic [LEVEL_W-1:0] red;
    logic [LEVEL_W-1:0] green;
    logic [LEVEL_W-1:0] blue;
    logic [DUR_W-1:0]   duration;
    logic               link;
  } cmd_word_t;

  logic                  clk;
  logic                  rst;
  logic                  wr_en;
  logic [CFG_IDX_W-1:0]  wr_index;
  logic [CFG_DATA_W-1:0] wr_data;

  rgblf_in_if  in_ch ();
  rgblf_out_if out_ch ();

  rgb_led_fade_blink_controller_unit u_top (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (wr_en),
    .wr_index (wr_index),
    .wr_data  (wr_data),
    .in_ch    (in_ch),
    .out_ch   (out_ch)
  );

  logic                   led_on;
  logic [FADE_RATE_W-1:0] fade_rate;
  logic [LEVEL_W-1:0]     shown [NUM_LANES];
  logic [LEVEL_W-1:0]     target [NUM_LANES];
  logic [LEVEL_W-1:0]     blink_color [NUM_LANES];
  logic [DUR_W-1:0]       flash_len;
  logic [DUR_W-1:0]       blink_half;
  logic                   offline;
  logic [FADE_CNT_W-1:0]  fade_us;
  logic [PRESCALE_W-1:0]  prescale;
  logic [MS_CNT_W-1:0]    flash_ms;
  logic [MS_CNT_W-1:0]    blink_ms;

  cmd_word_t word_queue [$];
  result_t   levels_expected [$];

  int mismatches;
  int words_pushed;
  int gap_left;
  int stall_left;
  int hold_left;
  bit in_taken;
  bit src_idle;
  bit snk_idle;
  bit hold_req;
  bit hold_started;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #30_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  function automatic result_t predict_levels(cmd_word_t w);
    logic    differ;
    result_t res;
    differ = 1'b0;
    if (w.mode == MODE_TICK) begin
      if (fade_us != '1) fade_us = fade_us + 1'b1;
      prescale = prescale + 1'b1;
      if (prescale >= DEF_US_PER_MS) begin
        prescale = '0;
        if (flash_ms != '1) flash_ms = flash_ms + 1'b1;
        if (blink_ms != '1) blink_ms = blink_ms + 1'b1;
      end
      if (!w.link && !offline) begin
        blink_ms    = '0;
        blink_half  = DUR_W'(DEF_OFFLINE_BLINK_MS);
        flash_len   = '0;
        target      = '{LEVEL_FULL, LEVEL_DARK, LEVEL_DARK};
        blink_color = target;
        offline     = 1'b1;
      end else if (!led_on) begin
        blink_half = '0;
        flash_len  = '0;
        target     = '{default: LEVEL_DARK};
      end
      if (w.link) offline = 1'b0;
      for (int i = 0; i < NUM_LANES; i++) begin
        if (target[i] != shown[i]) differ = 1'b1;
      end
      if (differ) begin
        if (fade_rate != '0) begin
          if (int'(fade_us) >= int'(fade_rate) * DEF_FADE_UNIT_US) begin
            fade_us = '0;
            for (int i = 0; i < NUM_LANES; i++) begin
              if (target[i] > shown[i]) shown[i] = shown[i] + 1'b1;
              else if (target[i] < shown[i]) shown[i] = shown[i] - 1'b1;
            end
          end
        end else begin
          shown = target;
        end
      end
      if (flash_len != '0 && int'(flash_ms) >= int'(flash_len)) begin
        target    = '{default: LEVEL_DARK};
        flash_len = '0;
      end
      if (blink_half != '0) begin
        if (int'(blink_ms) >= int'(blink_half)) target = blink_color;
        if (int'(blink_ms) >= 2 * int'(blink_half)) begin
          target   = '{default: LEVEL_DARK};
          blink_ms = '0;
        end
      end
    end else begin
      target     = '{w.red, w.green, w.blue};
      flash_len  = '0;
      blink_half = '0;
      if (w.mode == MODE_FLASH) begin
        flash_ms  = '0;
        flash_len = w.duration;
      end
      if (w.mode == MODE_BLINK) begin
        blink_ms    = '0;
        blink_half  = w.duration;
        blink_color = target;
      end
    end
    res.red     = shown[0];
    res.green   = shown[1];
    res.blue    = shown[2];
    res.offline = offline;
    return res;
  endfunction

  function automatic int idle_len();
    int p;
    p = $urandom_range(0, 99);
    if (p < 70) return $urandom_range(1, 3);
    else if (p < 95) return $urandom_range(4, 10);
    else return $urandom_range(20, 40);
  endfunction

  function automatic logic [LEVEL_W-1:0] rand_level();
    int p;
    p = $urandom_range(0, 7);
    if (p == 0) return LEVEL_DARK;
    else if (p == 1) return LEVEL_FULL;
    else return LEVEL_W'($urandom);
  endfunction

  function automatic logic [DUR_W-1:0] rand_duration();
    int p;
    p = $urandom_range(0, 99);
    if (p < 60) return DUR_W'($urandom_range(1, 2));
    else if (p < 75) return '0;
    else if (p < 85) return '1;
    else return DUR_W'($urandom);
  endfunction

  task automatic push_word(input mode_t mode, input logic [LEVEL_W-1:0] r,
                           input logic [LEVEL_W-1:0] g, input logic [LEVEL_W-1:0] b,
                           input logic [DUR_W-1:0] dur, input logic link);
    cmd_word_t w;
    w.mode     = mode;
    w.red      = r;
    w.green    = g;
    w.blue     = b;
    w.duration = dur;
    w.link     = link;
    word_queue.push_back(w);
    words_pushed++;
  endtask

  // Link drop chance is given per thousand ticks.
  task automatic push_ticks(input int n, input int drop_per_mille);
    for (int i = 0; i < n; i++) begin
      push_word(MODE_TICK, LEVEL_W'($urandom), LEVEL_W'($urandom), LEVEL_W'($urandom),
                DUR_W'($urandom), $urandom_range(0, 999) >= drop_per_mille);
    end
  endtask

  // Mostly a command followed by a run of ticks; the rest is loose noise.
  task automatic push_random_burst();
    int p;
    p = $urandom_range(0, 99);
    if (p < 80) begin
      push_word(mode_t'($urandom_range(1, 3)), rand_level(), rand_level(), rand_level(),
                rand_duration(), 1'($urandom_range(0, 1)));
      push_ticks($urandom_range(5, 60), 5);
    end else begin
      push_word(mode_t'($urandom_range(0, 3)), LEVEL_W'($urandom), LEVEL_W'($urandom),
                LEVEL_W'($urandom), DUR_W'($urandom), 1'($urandom_range(0, 1)));
    end
  endtask

  task automatic wait_drained();
    while (word_queue.size() != 0 || in_ch.valid || levels_expected.size() != 0) begin
      @(negedge clk);
    end
  endtask

  task automatic settle_and_configure(input logic en, input logic [FADE_RATE_W-1:0] rate);
    wait_drained();
    repeat (3) @(negedge clk);
    wr_en    <= 1'b1;
    wr_index <= CFG_LED_ENABLE;
    wr_data  <= CFG_DATA_W'(en);
    @(negedge clk);
    wr_index <= CFG_FADE_RATE;
    wr_data  <= rate;
    @(negedge clk);
    wr_en     <= 1'b0;
    led_on    = en;
    fade_rate = rate;
  endtask

  always @(negedge clk) begin
    cmd_word_t w;
    if (rst) begin
      in_ch.valid <= 1'b0;
    end else if (!in_ch.valid || in_taken) begin
      if (gap_left > 0) begin
        gap_left--;
        in_ch.valid <= 1'b0;
      end else if (word_queue.size() != 0) begin
        w = word_queue.pop_front();
        in_ch.valid       <= 1'b1;
        in_ch.mode        <= w.mode;
        in_ch.red_in      <= w.red;
        in_ch.green_in    <= w.green;
        in_ch.blue_in     <= w.blue;
        in_ch.duration_ms <= w.duration;
        in_ch.link_up     <= w.link;
        if (src_idle && $urandom_range(0, 3) == 0) gap_left = idle_len();
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    if (rst) begin
      out_ch.ready <= 1'b0;
    end else if (hold_req && !hold_started) begin
      hold_started = 1'b1;
      hold_left    = LONG_HOLD - 1;
      out_ch.ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      out_ch.ready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= 1'b1;
      if (snk_idle && $urandom_range(0, 3) == 0) stall_left = idle_len();
    end
  end

  always @(posedge clk) begin
    cmd_word_t w;
    result_t   got;
    result_t   want;
    in_taken <= in_ch.valid && in_ch.ready;
    if (!rst) begin
      if (in_ch.valid && in_ch.ready) begin
        w.mode     = mode_t'(in_ch.mode);
        w.red      = in_ch.red_in;
        w.green    = in_ch.green_in;
        w.blue     = in_ch.blue_in;
        w.duration = in_ch.duration_ms;
        w.link     = in_ch.link_up;
        levels_expected.push_back(predict_levels(w));
      end
      if (out_ch.valid && out_ch.ready) begin
        got.red     = out_ch.red_level;
        got.green   = out_ch.green_level;
        got.blue    = out_ch.blue_level;
        got.offline = out_ch.offline_flag;
        if (levels_expected.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("level word with none expected: r=%0d g=%0d b=%0d off=%0b",
                     got.red, got.green, got.blue, got.offline);
          end
        end else begin
          want = levels_expected.pop_front();
          if (got !== want) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("level word mismatch: expected r=%0d g=%0d b=%0d off=%0b, got r=%0d g=%0d b=%0d off=%0b",
                       want.red, want.green, want.blue, want.offline,
                       got.red, got.green, got.blue, got.offline);
            end
          end
        end
      end
    end
  end

  initial begin
    int          stop_at;
    logic        set_en [RANDOM_SETS];
    logic [9:0]  set_rate [RANDOM_SETS];
    set_en   = '{1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b1};
    set_rate = '{10'd0, 10'd0, 10'd1, 10'd3, 10'd2, 10'h3FF};

    rst               = 1'b1;
    wr_en             = 1'b0;
    wr_index          = CFG_LED_ENABLE;
    wr_data           = '0;
    in_ch.valid       = 1'b0;
    in_ch.mode        = MODE_TICK;
    in_ch.red_in      = '0;
    in_ch.green_in    = '0;
    in_ch.blue_in     = '0;
    in_ch.duration_ms = '0;
    in_ch.link_up     = 1'b1;
    out_ch.ready      = 1'b0;
    src_idle          = 1'b1;
    snk_idle          = 1'b1;

    led_on      = 1'b1;
    fade_rate   = '0;
    shown       = '{LEVEL_DARK, GREEN_BOOT, LEVEL_FULL};
    target      = '{default: LEVEL_DARK};
    blink_color = '{default: LEVEL_DARK};
    flash_len   = '0;
    blink_half  = '0;
    offline     = 1'b0;
    fade_us     = '0;
    prescale    = '0;
    flash_ms    = '0;
    blink_ms    = '0;

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed words: field extremes, zero durations, link loss and release.
    push_word(MODE_TICK, 8'd0, 8'd0, 8'd0, 16'd0, 1'b1);
    push_word(MODE_SET, 8'd255, 8'd255, 8'd255, 16'd0, 1'b1);
    push_word(MODE_TICK, 8'd0, 8'd0, 8'd0, 16'd0, 1'b1);
    push_word(MODE_SET, 8'd0, 8'd0, 8'd0, 16'hFFFF, 1'b1);
    push_word(MODE_FLASH, 8'h12, 8'h34, 8'h56, 16'd0, 1'b1);
    push_word(MODE_TICK, 8'd0, 8'd0, 8'd0, 16'd0, 1'b1);
    push_word(MODE_BLINK, 8'hAA, 8'h55, 8'hFF, 16'd0, 1'b1);
    push_word(MODE_TICK, 8'hFF, 8'hFF, 8'hFF, 16'hFFFF, 1'b1);
    push_word(MODE_FLASH, 8'd255, 8'd0, 8'd255, 16'hFFFF, 1'b1);
    push_word(MODE_TICK, 8'd0, 8'd0, 8'd0, 16'd0, 1'b1);
    push_word(MODE_BLINK, 8'd0, 8'd255, 8'd0, 16'hFFFF, 1'b1);
    push_word(MODE_TICK, 8'd0, 8'd0, 8'd0, 16'd0, 1'b1);
    push_word(MODE_TICK, 8'd0, 8'd0, 8'd0, 16'd0, 1'b0);
    push_word(MODE_TICK, 8'd0, 8'd0, 8'd0, 16'd0, 1'b0);
    push_word(MODE_SET, 8'd1, 8'd2, 8'd3, 16'd0, 1'b0);
    push_word(MODE_TICK, 8'd0, 8'd0, 8'd0, 16'd0, 1'b1);
    push_word(MODE_BLINK, 8'd80, 8'd40, 8'd20, 16'd1, 1'b1);
    push_word(MODE_TICK, 8'd0, 8'd0, 8'd0, 16'd0, 1'b1);
    push_word(MODE_FLASH, 8'd255, 8'd255, 8'd255, 16'd1, 1'b1);
    push_word(MODE_TICK, 8'd0, 8'd0, 8'd0, 16'd0, 1'b1);
    push_word(MODE_TICK, 8'd0, 8'd0, 8'd0, 16'd0, 1'b0);
    push_word(MODE_TICK, 8'd0, 8'd0, 8'd0, 16'd0, 1'b1);

    // Random sets; the first one runs a long output hold against a busy sender.
    for (int s = 0; s < RANDOM_SETS; s++) begin
      settle_and_configure(set_en[s], set_rate[s]);
      src_idle = (s != 0) && (s != 2);
      snk_idle = (s != 2);
      hold_req = (s == 0);
      stop_at  = words_pushed + RANDOM_WORDS / RANDOM_SETS;
      while (words_pushed < stop_at) push_random_burst();
    end

    // Millisecond timing: a fading blink, then a flash, then the offline blink.
    // The two runs of ticks together span more than one millisecond.
    src_idle = 1'b1;
    snk_idle = 1'b1;
    settle_and_configure(1'b1, 10'd1);
    push_word(MODE_BLINK, 8'd10, 8'd200, 8'd30, 16'd1, 1'b1);
    push_ticks(550, 0);
    push_word(MODE_FLASH, rand_level(), rand_level(), rand_level(), 16'd1, 1'b1);
    push_ticks(550, 0);
    push_ticks(20, 1000);
    push_ticks(130, 0);

    wait_drained();
    repeat (5) @(negedge clk);
    if (mismatches == 0 && levels_expected.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// ----- files.f -----
hw/rtl/rgblf_pkg.sv
hw/rtl/rgblf_if.sv
hw/rtl/rgblf_lane.sv
hw/rtl/rgblf_ctrl.sv
hw/rtl/rgb_led_fade_blink_controller_unit.sv
dv/tb_rgb_led_fade_blink_controller_unit.sv
